// File: src/sgm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgm_pkg
// shared constants and types of the sobel gradient magnitude block
// ----------------------------------------------------------------------------
package sgm_pkg;

   localparam int unsigned DEF_MAX_WIDTH  = 4096;
   localparam int unsigned DEF_PIXEL_BITS = 8;
   localparam int unsigned MAX_HEIGHT     = 4096;
   localparam int unsigned DIM_BITS       = 13;
   localparam int unsigned POS_BITS       = 12;
   localparam int unsigned MAG_BITS       = 11;
   localparam int unsigned SQ_BITS        = 24;
   localparam logic [MAG_BITS-1:0] MAG_MAX = 11'd2047;

   localparam logic [0:0] REG_WIDTH  = 1'b0;
   localparam logic [0:0] REG_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SUM,
      ST_SQUARE,
      ST_ROOT,
      ST_EMIT
   } state_type;

endpackage : sgm_pkg
`default_nettype wire

// File: src/sgm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgm_ram
// single port synchronous ram, registered read
// ----------------------------------------------------------------------------
module sgm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule : sgm_ram
`default_nettype wire

// File: src/sobel_gradient_magnitude.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude
// streaming 3x3 sobel magnitude with border replication
// ----------------------------------------------------------------------------
// channel | dir | contents
// req     | in  | tdata: grey_pixel
// rsp     | out | tdata: out_row, out_col, magnitude; tuser: last_of_run; tlast
// csr     | in  | write enable, index, 13-bit data
//
// a pixel without a full window passes through accept, two ram reads and the
// sums. with a window it also passes through square, the bit-serial root and
// emit, where each result waits for rsp_tready. the root unit resolves one
// bit of the 11-bit result per cycle. the two line stores share one ram; read
// and write of the same entry happen in separate cycles. a stalled result
// holds the input off. reset is synchronous and clears the counters and
// window; no memory sweep.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude
   import sgm_pkg::*;
#(
   parameter int unsigned PIXEL_BITS = DEF_PIXEL_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,   // [7:0] grey_pixel
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [39:0]              rsp_tdata,   // [11:0] out_row, [23:12] out_col,
                                                 // [34:24] magnitude, zero fill
   output logic                     rsp_tuser,   // [0] last_of_run
   output logic                     rsp_tlast,   // frame_end
   input  wire logic                csr_we,
   input  wire logic [0:0]          csr_index,
   input  wire logic [DIM_BITS-1:0] csr_wdata
);

   localparam int unsigned MAX_WIDTH = DEF_MAX_WIDTH;
   localparam int unsigned CB = $clog2(MAX_WIDTH);
   localparam int unsigned AB = CB + 1;
   localparam int unsigned GB = PIXEL_BITS + 3;      // signed gradient width
   localparam int unsigned SB = 2 * PIXEL_BITS + 6;  // sum of squares
   localparam int unsigned RB = (SB + 1) / 2;        // root width
   localparam int unsigned RI = RB;                  // root iterations

   // ---------------- configuration ----------------
   logic [DIM_BITS-1:0] width_ff, height_ff, width_in, height_in;
   logic [DIM_BITS-1:0] w_eff, h_eff;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_WIDTH:  width_in  = csr_wdata;
            REG_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
      if (width_ff < DIM_BITS'(3)) w_eff = DIM_BITS'(3);
      else if (width_ff > DIM_BITS'(MAX_WIDTH)) w_eff = DIM_BITS'(MAX_WIDTH);
      else w_eff = width_ff;
      if (height_ff < DIM_BITS'(3)) h_eff = DIM_BITS'(3);
      else if (height_ff > DIM_BITS'(MAX_HEIGHT)) h_eff = DIM_BITS'(MAX_HEIGHT);
      else h_eff = height_ff;
   end

   // ---------------- state ----------------
   state_type state_ff, state_in;
   logic [POS_BITS-1:0]   row_ff, row_in, col_ff, col_in;
   logic [PIXEL_BITS-1:0] pix_ff, pix_in;
   logic [PIXEL_BITS-1:0] win_ff [9];
   logic [PIXEL_BITS-1:0] win_in [9];
   logic [PIXEL_BITS-1:0] top_ff, top_in;
   logic                  rd_sel_ff, rd_sel_in;   // 0: top read, 1: mid read
   logic                  has_win_ff, has_win_in, lastpx_ff, lastpx_in;
   logic [POS_BITS-1:0]   cr_ff, cr_in, cc_ff, cc_in;
   logic signed [GB-1:0]  gx_ff, gx_in, gy_ff, gy_in;
   logic [SB-1:0]         rem_ff, rem_in;
   logic [SB:0]           res_ff, res_in;
   logic [SB-1:0]         bit_ff, bit_in;
   logic [$clog2(RI+1)-1:0] it_ff, it_in;
   logic [1:0]            ri_ff, ri_in, ci_ff, ci_in;   // emit indices
   logic [1:0]            nr, nc;
   logic [POS_BITS-1:0]   rows [3];
   logic [POS_BITS-1:0]   cols [3];

   // ---------------- line store ----------------
   logic              ram_we;
   logic [AB-1:0]     ram_addr;
   logic [PIXEL_BITS-1:0] ram_rd;
   logic [CB-1:0]     cidx;

   assign cidx = col_ff[CB-1:0];

   sgm_ram #(.WIDTH(PIXEL_BITS), .DEPTH(2 * MAX_WIDTH)) u_line_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(pix_ff),
      .rd_data(ram_rd)
   );

   always_comb begin
      ram_we   = 1'b0;
      ram_addr = {row_ff[0], cidx};
      unique case (state_ff)
         ST_IDLE: ram_addr = {row_ff[0], cidx};
         ST_READ: begin
            if (!rd_sel_ff) ram_addr = {~row_ff[0], cidx};
            else begin
               ram_addr = {row_ff[0], cidx};
               ram_we   = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // ---------------- sobel and root ----------------
   logic signed [GB-1:0] sx, sy;
   logic [SB-1:0]        sq;
   logic [SB:0]          trial;
   logic [2*GB-1:0]      gx2, gy2;

   always_comb begin
      sx = GB'(win_ff[0]) + (GB'(win_ff[3]) <<< 1) + GB'(win_ff[6])
         - GB'(win_ff[2]) - (GB'(win_ff[5]) <<< 1) - GB'(win_ff[8]);
      sy = GB'(win_ff[0]) + (GB'(win_ff[1]) <<< 1) + GB'(win_ff[2])
         - GB'(win_ff[6]) - (GB'(win_ff[7]) <<< 1) - GB'(win_ff[8]);
      gx2 = unsigned'((2*GB)'(gx_ff) * (2*GB)'(gx_ff));
      gy2 = unsigned'((2*GB)'(gy_ff) * (2*GB)'(gy_ff));
      sq  = SB'(gx2) + SB'(gy2);
      trial = res_ff + (SB+1)'(bit_ff);
   end

   // result row and column lists
   always_comb begin
      rows[0] = cr_ff; rows[1] = cr_ff; rows[2] = cr_ff;
      cols[0] = cc_ff; cols[1] = cc_ff; cols[2] = cc_ff;
      nr = 2'd1;
      nc = 2'd1;
      if (cr_ff == POS_BITS'(1)) begin
         rows[0] = '0;
         rows[1] = cr_ff;
         nr = 2'd2;
      end
      if (({1'b0, cr_ff} == h_eff - DIM_BITS'(2)) && h_eff > DIM_BITS'(3)) begin
         rows[nr] = POS_BITS'(h_eff - DIM_BITS'(1));
         nr = nr + 2'd1;
      end
      if (cc_ff == POS_BITS'(1)) begin
         cols[0] = '0;
         cols[1] = cc_ff;
         nc = 2'd2;
      end
      if (({1'b0, cc_ff} == w_eff - DIM_BITS'(2)) && w_eff > DIM_BITS'(3)) begin
         cols[nc] = POS_BITS'(w_eff - DIM_BITS'(1));
         nc = nc + 2'd1;
      end
   end

   logic last_r, last_c;
   assign last_r = (ri_ff + 2'd1 == nr);
   assign last_c = (ci_ff + 2'd1 == nc);

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_READ;
         ST_READ:   if (rd_sel_ff) state_in = ST_SUM;
         ST_SUM:    state_in = has_win_ff ? ST_SQUARE : ST_IDLE;
         ST_SQUARE: state_in = ST_ROOT;
         ST_ROOT:   if (it_ff == ($clog2(RI+1))'(RI - 1)) state_in = ST_EMIT;
         ST_EMIT:   if (rsp_tready && last_r && last_c) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
      if (csr_we) state_in = ST_IDLE;
   end

   // ---------------- datapath ----------------
   always_comb begin
      row_in = row_ff; col_in = col_ff; pix_in = pix_ff;
      win_in = win_ff; top_in = top_ff; rd_sel_in = rd_sel_ff;
      has_win_in = has_win_ff; lastpx_in = lastpx_ff;
      cr_in = cr_ff; cc_in = cc_ff; gx_in = gx_ff; gy_in = gy_ff;
      rem_in = rem_ff; res_in = res_ff; bit_in = bit_ff; it_in = it_ff;
      ri_in = ri_ff; ci_in = ci_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rd_sel_in = 1'b0;
            if (req_tvalid) pix_in = PIXEL_BITS'(req_tdata);
         end
         ST_READ: begin
            if (!rd_sel_ff) begin
               top_in    = ram_rd;
               rd_sel_in = 1'b1;
            end else begin
               // shift window, new column on the right
               for (int k = 0; k < 3; k++) begin
                  win_in[k*3+0] = win_ff[k*3+1];
                  win_in[k*3+1] = win_ff[k*3+2];
               end
               win_in[2] = top_ff;
               win_in[5] = ram_rd;
               win_in[8] = pix_ff;
               has_win_in = (row_ff >= POS_BITS'(2)) && (col_ff >= POS_BITS'(2));
               lastpx_in  = ({1'b0, row_ff} == h_eff - DIM_BITS'(1))
                         && ({1'b0, col_ff} == w_eff - DIM_BITS'(1));
               cr_in = row_ff - POS_BITS'(1);
               cc_in = col_ff - POS_BITS'(1);
               if ({1'b0, col_ff} + DIM_BITS'(1) >= w_eff) begin
                  col_in = '0;
                  row_in = ({1'b0, row_ff} + DIM_BITS'(1) >= h_eff)
                         ? '0 : row_ff + POS_BITS'(1);
               end else begin
                  col_in = col_ff + POS_BITS'(1);
               end
            end
         end
         ST_SUM: begin
            gx_in = sx;
            gy_in = sy;
         end
         ST_SQUARE: begin
            rem_in = sq;
            res_in = '0;
            bit_in = SB'(1) << (2 * (RI - 1));
            it_in  = '0;
         end
         ST_ROOT: begin
            if ({1'b0, rem_ff} >= trial) begin
               rem_in = rem_ff - SB'(trial);
               res_in = (res_ff >> 1) + (SB+1)'(bit_ff);
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            it_in  = it_ff + 1'b1;
            ri_in  = '0;
            ci_in  = '0;
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               if (last_c) begin
                  ci_in = '0;
                  ri_in = ri_ff + 2'd1;
               end else begin
                  ci_in = ci_ff + 2'd1;
               end
            end
         end
         default: ;
      endcase
      if (csr_we) begin
         row_in = '0;
         col_in = '0;
      end
   end

   // ---------------- outputs ----------------
   logic [MAG_BITS-1:0] mag_out;
   always_comb begin
      if (res_ff > (SB+1)'(MAG_MAX)) mag_out = MAG_MAX;
      else mag_out = MAG_BITS'(res_ff);
      req_tready = (state_ff == ST_IDLE) && !csr_we;
      rsp_tvalid = (state_ff == ST_EMIT);
      rsp_tdata  = {5'd0, mag_out, cols[ci_ff], rows[ri_ff]};
      rsp_tuser  = last_r && last_c;
      rsp_tlast  = last_r && last_c && lastpx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         width_ff  <= DIM_BITS'(640);
         height_ff <= DIM_BITS'(480);
         row_ff    <= '0;
         col_ff    <= '0;
         rd_sel_ff <= 1'b0;
         for (int k = 0; k < 9; k++) win_ff[k] <= '0;
      end else begin
         state_ff  <= state_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         rd_sel_ff <= rd_sel_in;
         win_ff    <= win_in;
      end
      pix_ff <= pix_in; top_ff <= top_in;
      has_win_ff <= has_win_in; lastpx_ff <= lastpx_in;
      cr_ff <= cr_in; cc_ff <= cc_in; gx_ff <= gx_in; gy_ff <= gy_in;
      rem_ff <= rem_in; res_ff <= res_in; bit_ff <= bit_in; it_ff <= it_in;
      ri_ff <= ri_in; ci_ff <= ci_in;
   end

endmodule : sobel_gradient_magnitude
`default_nettype wire

// File: verif/sobel_gradient_magnitude_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_checker
// watches the pixel, result and register channels, computes the expected
// edge magnitudes with border copies and compares every result transfer
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_checker
   import sgm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   input  wire logic                req_tready,
   input  wire logic [7:0]          req_tdata,
   input  wire logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire logic [39:0]         rsp_tdata,
   input  wire logic                rsp_tuser,
   input  wire logic                rsp_tlast,
   input  wire logic                csr_we,
   input  wire logic [0:0]          csr_index,
   input  wire logic [DIM_BITS-1:0] csr_wdata,
   output int                       error_count,
   output int                       pending_count
);

   typedef struct packed {
      logic [POS_BITS-1:0] row;
      logic [POS_BITS-1:0] col;
      logic [MAG_BITS-1:0] mag;
      logic                run_last;
      logic                frame_last;
   } edge_result_type;

   edge_result_type      expected_q[$];
   logic [7:0]           line_mem[0:2*DEF_MAX_WIDTH-1];
   logic [7:0]           win[0:8];
   logic [DIM_BITS-1:0]  width_reg;
   logic [DIM_BITS-1:0]  height_reg;
   int unsigned          row_pos;
   int unsigned          col_pos;

   initial begin
      error_count = 0;
      foreach (line_mem[i]) line_mem[i] = '0;
   end

   assign pending_count = expected_q.size();

   function automatic int unsigned clamp_dim(logic [DIM_BITS-1:0] v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned int_sqrt(int unsigned v);
      int unsigned root;
      root = 0;
      for (int b = 11; b >= 0; b--) begin
         if ((root | (1 << b)) * (root | (1 << b)) <= v) root = root | (1 << b);
      end
      return root;
   endfunction

   task automatic report(string what, edge_result_type got, edge_result_type want);
      error_count++;
      $display("%0t mismatch %s: got row %0d col %0d mag %0d last %0d end %0d, %s",
               $time, what, got.row, got.col, got.mag, got.run_last, got.frame_last,
               $sformatf("want row %0d col %0d mag %0d last %0d end %0d",
                         want.row, want.col, want.mag, want.run_last, want.frame_last));
   endtask

   task automatic predict_pixel(logic [7:0] pix);
      int unsigned w, h, cur_bank, prev_bank, cr, cc, nr, nc, sq, mag;
      int          gx, gy;
      int unsigned rows[2];
      int unsigned cols[2];
      logic [7:0]  top_px, mid_px;
      edge_result_type item;
      w = clamp_dim(width_reg, DEF_MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      cur_bank  = (row_pos & 1) * DEF_MAX_WIDTH + col_pos;
      prev_bank = ((row_pos + 1) & 1) * DEF_MAX_WIDTH + col_pos;
      top_px = line_mem[cur_bank];
      mid_px = line_mem[prev_bank];
      line_mem[cur_bank] = pix;
      for (int k = 0; k < 3; k++) begin
         win[k*3]   = win[k*3+1];
         win[k*3+1] = win[k*3+2];
      end
      win[2] = top_px;
      win[5] = mid_px;
      win[8] = pix;
      if (row_pos >= 2 && col_pos >= 2) begin
         gx = (int'(win[0]) + 2*win[3] + win[6]) - (int'(win[2]) + 2*win[5] + win[8]);
         gy = (int'(win[0]) + 2*win[1] + win[2]) - (int'(win[6]) + 2*win[7] + win[8]);
         sq = gx*gx + gy*gy;
         mag = int_sqrt(sq);
         if (mag > MAG_MAX) mag = MAG_MAX;
         cr = row_pos - 1;
         cc = col_pos - 1;
         nr = 0;
         nc = 0;
         // border rows and columns copy the nearest interior result
         if (cr == 1) begin
            rows[nr] = 0;
            nr = nr + 1;
         end
         rows[nr] = cr;
         nr = nr + 1;
         if (cr == h - 2 && h > 3) begin
            rows[nr] = h - 1;
            nr = nr + 1;
         end
         if (cc == 1) begin
            cols[nc] = 0;
            nc = nc + 1;
         end
         cols[nc] = cc;
         nc = nc + 1;
         if (cc == w - 2 && w > 3) begin
            cols[nc] = w - 1;
            nc = nc + 1;
         end
         for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
               item.row = rows[i];
               item.col = cols[j];
               item.mag = mag;
               item.run_last = (i == nr - 1) && (j == nc - 1);
               item.frame_last = item.run_last && row_pos == h - 1 && col_pos == w - 1;
               expected_q.push_back(item);
            end
         end
      end
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endtask

   always @(posedge clock) begin
      edge_result_type got, want;
      if (reset) begin
         width_reg  = 640;
         height_reg = 480;
         row_pos    = 0;
         col_pos    = 0;
         foreach (win[i]) win[i] = '0;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == REG_WIDTH) width_reg = csr_wdata;
            else height_reg = csr_wdata;
            row_pos = 0;
            col_pos = 0;
         end
         if (req_tvalid && req_tready) predict_pixel(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got.row = rsp_tdata[11:0];
            got.col = rsp_tdata[23:12];
            got.mag = rsp_tdata[34:24];
            got.run_last = rsp_tuser;
            got.frame_last = rsp_tlast;
            if (expected_q.size() == 0) begin
               report("unexpected transfer", got, '0);
            end else begin
               want = expected_q.pop_front();
               if (got.row != want.row) report("out_row", got, want);
               else if (got.col != want.col) report("out_col", got, want);
               else if (got.mag != want.mag) report("magnitude", got, want);
               else if (got.run_last != want.run_last) report("last_of_run", got, want);
               else if (got.frame_last != want.frame_last) report("frame_end", got, want);
            end
         end
      end
   end

endmodule : sobel_gradient_magnitude_checker

// File: verif/sobel_gradient_magnitude_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_tb
// drives pixel frames of many sizes, including three-wide, three-high and
// clamped register values, with random gaps and back-pressure
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_tb;
   import sgm_pkg::*;

   localparam int IDLE_LIMIT = 4000;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [7:0]          req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [39:0]         rsp_tdata;
   logic                rsp_tuser;
   logic                rsp_tlast;
   logic                csr_we;
   logic [0:0]          csr_index;
   logic [DIM_BITS-1:0] csr_wdata;
   int                  error_count;
   int                  pending_count;
   bit                  calm;
   int                  quiet_cycles;

   sobel_gradient_magnitude dut (.*);

   sobel_gradient_magnitude_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = REG_WIDTH;
      csr_wdata = '0;
      calm = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= 30);
   end

   // any transfer, register write or reset clears the hang counter
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_pixel(logic [7:0] pix);
      while (!calm && $urandom_range(0, 99) < 30) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop the stream, drain all results and let the pipeline settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [DIM_BITS-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_frame(logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
   endtask

   function automatic logic [7:0] random_pixel();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      int sent, w, h, count;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // three-wide, three-high frame written as out-of-range values (clamped)
      set_frame(DIM_BITS'(0), DIM_BITS'(1));
      for (int i = 0; i < 9; i++) send_pixel((i % 3 == 0) ? 8'hff : 8'h00);
      drain();
      // four by four checkerboard of extremes
      set_frame(DIM_BITS'(4), DIM_BITS'(4));
      for (int i = 0; i < 16; i++) send_pixel(((i + i / 4) % 2) ? 8'hff : 8'h00);
      drain();

      sent = 0;
      for (int phase = 0; sent < 100; phase++) begin
         calm = (phase % 5 == 2);
         w = $urandom_range(3, 8);
         h = $urandom_range(3, 6);
         set_frame(DIM_BITS'(w), DIM_BITS'(h));
         case ($urandom_range(0, 9))
            0, 1: count = $urandom_range(1, w * h - 1);
            2: count = 2 * w * h;
            default: count = w * h;
         endcase
         for (int i = 0; i < count; i++) send_pixel(random_pixel());
         sent += count;
         drain();
      end
      calm = 1'b0;

      // widest frame: all-ones width clamps to the maximum, first pixels only
      set_frame(DIM_BITS'(8191), DIM_BITS'(3));
      for (int i = 0; i < 12; i++) send_pixel(random_pixel());
      drain();
      // tallest frame, only the first rows
      set_frame(DIM_BITS'(3), DIM_BITS'(4096));
      for (int i = 0; i < 24; i++) send_pixel(random_pixel());
      drain();
      set_frame(DIM_BITS'(5), DIM_BITS'(8191));
      for (int i = 0; i < 30; i++) send_pixel(random_pixel());
      drain();

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule : sobel_gradient_magnitude_tb

// File: filelist.f
src/sgm_pkg.sv
src/sgm_ram.sv
src/sobel_gradient_magnitude.sv
verif/sobel_gradient_magnitude_checker.sv
verif/sobel_gradient_magnitude_tb.sv
